### src/egms_pkg.sv
`default_nettype none

package egms_pkg;

    localparam int STATE_COUNT = 19683;
    localparam int VALUE_BITS  = 32;
    localparam int MOVES       = 9;
    localparam int Q_DEPTH     = STATE_COUNT * MOVES;
    localparam int ADDR_BITS   = $clog2(Q_DEPTH);
    localparam int STATE_BITS  = 15;
    localparam int PICK_BITS   = 16;
    localparam int MOD_STEPS   = PICK_BITS / 2;

    localparam logic [15:0] EPS_RESET = 16'd6554;

    localparam logic [1:0] CELL_EMPTY = 2'd0;
    localparam logic [1:0] CELL_X     = 2'd1;
    localparam logic [1:0] CELL_O     = 2'd2;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_CHOOSE = 1'b1;

    typedef logic signed [VALUE_BITS-1:0] value_t;

    typedef struct packed {
        logic               func;
        logic [17:0]        board;
        logic               ai_turn;
        logic [15:0]        rand_explore;
        logic [15:0]        rand_pick;
        logic [14:0]        load_state;
        logic [3:0]         load_move;
        logic signed [31:0] load_value;
    } in_item_t;

    typedef struct packed {
        logic       move_valid;
        logic [1:0] move_row;
        logic [1:0] move_col;
        logic       explored;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BASE,
        ST_READ,
        ST_DRAIN,
        ST_RESULT
    } sel_state_t;

    // base-3 board index, X weighs 1 and O weighs 2
    function automatic logic [STATE_BITS-1:0] base3_index(input logic [17:0] board);
        int sum;
        int w;
        sum = 0;
        w   = 1;
        for (int c = 0; c < MOVES; c++)
        begin
            if (board[2*c +: 2] == CELL_X)
            begin
                sum = sum + w;
            end
            else if (board[2*c +: 2] == CELL_O)
            begin
                sum = sum + 2 * w;
            end
            w = w * 3;
        end
        return STATE_BITS'(sum);
    endfunction

    function automatic logic [8:0] empty_cells(input logic [17:0] board);
        logic [8:0] e;
        for (int c = 0; c < MOVES; c++)
        begin
            e[c] = (board[2*c +: 2] == CELL_EMPTY);
        end
        return e;
    endfunction

    function automatic logic [3:0] count_ones9(input logic [8:0] v);
        logic [3:0] n;
        n = '0;
        for (int c = 0; c < MOVES; c++)
        begin
            n = n + {3'b0, v[c]};
        end
        return n;
    endfunction

endpackage

`default_nettype wire

### src/egms_ram.sv
`default_nettype none

module egms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### src/epsilon_greedy_move_select_unit.sv
// channel   direction  handshake          payload
// item      in         start & !busy      item (in_item_t)
// result    out        done, one cycle    result (out_item_t)
// config    in         cfg_we             cfg_data (epsilon threshold)
//
// an in-range load writes the q store at its accept edge and leaves busy low
// a choose transaction keeps busy high while it forms the row base, reads
// the row's nine q store entries (one read port, one cell per cycle),
// finishes the last compare and picks the move; done pulses in the cycle after that
// reset clears the sequencer and sets the threshold to 0.1; the q store is not cleared
// done cannot be held off; the result stays on its ports until the next one
`default_nettype none

module epsilon_greedy_move_select_unit
    import egms_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    output logic           busy,
    input  wire in_item_t  item,
    input  wire logic      cfg_we,
    input  wire logic [15:0] cfg_data,
    output out_item_t      result,
    output logic           done
);

    localparam logic [3:0] LAST_CELL = 4'(MOVES - 1);

    sel_state_t state_reg;
    sel_state_t state_next;

    logic [15:0]          eps_reg;

    // per transaction context
    logic [8:0]           empty_reg;
    logic                 ai_reg;
    logic [15:0]          rexp_reg;
    logic [15:0]          pick_reg;
    logic [STATE_BITS-1:0] idx_reg;
    logic [3:0]           count_reg;

    // read sequencer and compare stage
    logic [ADDR_BITS-1:0] addr_reg;
    logic [3:0]           cell_reg;
    logic                 cmp_vld_reg;
    logic [3:0]           cmp_cell_reg;
    logic                 have_reg;
    logic                 any_nz_reg;
    value_t               best_q_reg;
    logic [3:0]           best_cell_reg;

    // remainder unit, two pick bits per cycle
    logic [3:0]           rem_reg;
    logic [3:0]           step_cnt_reg;

    out_item_t            result_reg;
    logic                 done_reg;

    logic                 accept;
    logic                 choose_acc;
    logic                 ram_we;
    logic [ADDR_BITS-1:0] ram_waddr;
    logic                 rd_en;
    logic [VALUE_BITS-1:0] ram_rdata;
    value_t               q_rd;
    logic                 mod_run;

    logic                 explore;
    logic [3:0]           kth_cell;
    logic [3:0]           pick_cell;
    out_item_t            result_new;

    assign accept     = start && !busy;
    assign choose_acc = accept && (item.func == FUNC_CHOOSE);

    // in-range loads go straight into the store at the accept edge
    assign ram_we    = accept && (item.func == FUNC_LOAD)
                       && ({17'b0, item.load_state} < 32'(STATE_COUNT))
                       && ({28'b0, item.load_move} < 32'(MOVES));
    assign ram_waddr = ADDR_BITS'({item.load_state, 3'b000})
                       + ADDR_BITS'(item.load_state)
                       + ADDR_BITS'(item.load_move);

    egms_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (Q_DEPTH)
    ) u_q_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (VALUE_BITS'(item.load_value)),
        .re    (rd_en),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    assign q_rd = signed'(ram_rdata);

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        rd_en      = 1'b0;
        busy       = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (choose_acc)
                begin
                    state_next = ST_BASE;
                end
            end
            ST_BASE:
            begin
                state_next = ST_READ;
            end
            ST_READ:
            begin
                rd_en = 1'b1;
                if (cell_reg == LAST_CELL)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg <= EPS_RESET;
        end
        else if (cfg_we)
        begin
            eps_reg <= cfg_data;
        end
    end

    // capture the choose transaction
    always_ff @(posedge clk)
    begin
        if (choose_acc)
        begin
            empty_reg <= empty_cells(item.board);
            ai_reg    <= item.ai_turn;
            rexp_reg  <= item.rand_explore;
            idx_reg   <= base3_index(item.board);
            count_reg <= count_ones9(empty_cells(item.board));
        end
    end

    // row address, then one entry per cycle
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_BASE)
        begin
            addr_reg <= ADDR_BITS'({idx_reg, 3'b000}) + ADDR_BITS'(idx_reg);
            cell_reg <= '0;
        end
        else if (rd_en)
        begin
            addr_reg <= addr_reg + ADDR_BITS'(1);
            cell_reg <= cell_reg + 4'd1;
        end
    end

    // running argmax over empty cells, first empty cell seeds it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmp_vld_reg <= 1'b0;
            have_reg    <= 1'b0;
            any_nz_reg  <= 1'b0;
        end
        else
        begin
            cmp_vld_reg <= rd_en;
            if (choose_acc)
            begin
                have_reg   <= 1'b0;
                any_nz_reg <= 1'b0;
            end
            else if (cmp_vld_reg && empty_reg[cmp_cell_reg])
            begin
                if (q_rd != '0)
                begin
                    any_nz_reg <= 1'b1;
                end
                if (!have_reg || (q_rd > best_q_reg))
                begin
                    have_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_cell_reg <= cell_reg;
        if (cmp_vld_reg && empty_reg[cmp_cell_reg] && (!have_reg || (q_rd > best_q_reg)))
        begin
            best_q_reg    <= q_rd;
            best_cell_reg <= cmp_cell_reg;
        end
    end

    // restoring remainder of rand_pick by the empty count, msb first
    function automatic logic [3:0] rem_bit(input logic [3:0] r, input logic b,
                                           input logic [3:0] d);
        logic [4:0] t;
        t = {r, b};
        if (t >= {1'b0, d})
        begin
            t = t - {1'b0, d};
        end
        return t[3:0];
    endfunction

    assign mod_run = (state_reg == ST_BASE || state_reg == ST_READ)
                     && (step_cnt_reg != 4'(MOD_STEPS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_cnt_reg <= '0;
        end
        else if (choose_acc)
        begin
            step_cnt_reg <= '0;
        end
        else if (mod_run)
        begin
            step_cnt_reg <= step_cnt_reg + 4'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (choose_acc)
        begin
            pick_reg <= item.rand_pick;
            rem_reg  <= '0;
        end
        else if (mod_run)
        begin
            pick_reg <= {pick_reg[13:0], 2'b00};
            rem_reg  <= rem_bit(rem_bit(rem_reg, pick_reg[15], count_reg),
                                pick_reg[14], count_reg);
        end
    end

    // k-th empty cell, k = remainder
    always_comb
    begin
        logic [3:0] seen;
        logic       found;
        seen     = '0;
        found    = 1'b0;
        kth_cell = '0;
        for (int c = 0; c < MOVES; c++)
        begin
            if (empty_reg[c] && !found && (seen == rem_reg))
            begin
                found    = 1'b1;
                kth_cell = 4'(c);
            end
            seen = seen + {3'b0, empty_reg[c]};
        end
    end

    assign explore   = !any_nz_reg || (rexp_reg < eps_reg);
    assign pick_cell = explore ? kth_cell : best_cell_reg;

    always_comb
    begin
        result_new = '0;
        if (ai_reg && (count_reg != 4'd0))
        begin
            result_new.move_valid = 1'b1;
            result_new.explored   = explore;
            unique case (pick_cell)
                4'd0: begin result_new.move_row = 2'd0; result_new.move_col = 2'd0; end
                4'd1: begin result_new.move_row = 2'd0; result_new.move_col = 2'd1; end
                4'd2: begin result_new.move_row = 2'd0; result_new.move_col = 2'd2; end
                4'd3: begin result_new.move_row = 2'd1; result_new.move_col = 2'd0; end
                4'd4: begin result_new.move_row = 2'd1; result_new.move_col = 2'd1; end
                4'd5: begin result_new.move_row = 2'd1; result_new.move_col = 2'd2; end
                4'd6: begin result_new.move_row = 2'd2; result_new.move_col = 2'd0; end
                4'd7: begin result_new.move_row = 2'd2; result_new.move_col = 2'd1; end
                4'd8: begin result_new.move_row = 2'd2; result_new.move_col = 2'd2; end
                default: begin result_new.move_row = 2'd0; result_new.move_col = 2'd0; end
            endcase
        end
    end

    // result register, strobed for one cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            done_reg <= (state_reg == ST_RESULT);
            if (state_reg == ST_RESULT)
            begin
                result_reg <= result_new;
            end
        end
    end

    assign result = result_reg;
    assign done   = done_reg;

`ifndef SYNTHESIS
    a_done_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_RESULT))
        else $error("result strobe without a finished choose");

    a_mod_finished: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RESULT |-> step_cnt_reg == 4'(MOD_STEPS))
        else $error("remainder not finished at move pick");

    a_rem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RESULT && count_reg != 4'd0) |-> rem_reg < count_reg)
        else $error("remainder not below empty count");

    a_move_on_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.move_valid)
        |-> empty_reg[4'({result.move_row, 1'b0}) + 4'(result.move_row)
                      + 4'(result.move_col)])
        else $error("chosen cell is not empty");
`endif

endmodule

`default_nettype wire
